FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they expand to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/lis_pkg.sv
// ----------------------------------------------------------------------------
// LIS package
// Sizes, types and the search handshake shared by the subsequence unit.
// ----------------------------------------------------------------------------
package lis_pkg;

   localparam int MAX_ITEMS   = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(MAX_ITEMS);
   localparam int CNT_W       = $clog2(MAX_ITEMS + 1);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [CNT_W-1:0]              count_type;
   typedef logic [IDX_W-1:0]              index_type;

   typedef struct packed {
      logic      start;
      value_type value;
      count_type limit;
   } search_req_type;

   typedef struct packed {
      logic      done;
      count_type pos;
   } search_rsp_type;

endpackage

FILE: rtl/longest_increasing_subsequence_unit.sv
// ----------------------------------------------------------------------------
// Longest increasing subsequence unit
// Patience-sort LIS over a stream of signed values with a forward replay.
// ----------------------------------------------------------------------------
// Usage:
//   An item (req_value, req_final_req) is taken at a rising edge with start
//   high and busy low. Each item runs a lower-bound binary search over the
//   tails memory on a single shared compare; every search step is a
//   registered memory read, then a compare, and one more step stores the
//   item, with busy high throughout.
//   An item that arrives with the store full is dropped in its accept cycle
//   and raises the overflow flag of the run.
//   Non-final items give no result. After the final item the unit walks back
//   over the stored items, a read and then a compare per item visited, then
//   replays the subsequence forward: per element a read, then a result on
//   rsp_strobe carrying its rank, the total length and the overflow flag,
//   rsp_tail on the last one. Then the run is cleared and busy falls.
//   Results are shown for exactly one cycle; the receiver cannot stall them.
//   Reset (synchronous, active high) empties the run; the memories keep
//   their contents but are only read where written in the current run.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module longest_increasing_subsequence_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  lis_pkg::value_type  req_value,
   input  logic                req_final_req,
   output logic                rsp_strobe,
   output lis_pkg::value_type  rsp_element,
   output lis_pkg::count_type  rsp_rank,
   output lis_pkg::count_type  rsp_length,
   output logic                rsp_overflow,
   output logic                rsp_tail
);

   import lis_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SEARCH   = 3'd1;
   localparam logic [2:0] ST_WALK_RD  = 3'd2;
   localparam logic [2:0] ST_WALK_CMP = 3'd3;
   localparam logic [2:0] ST_EMIT_RD  = 3'd4;
   localparam logic [2:0] ST_EMIT_OUT = 3'd5;

   logic [2:0]     state_ff, state_in;
   value_type      value_ff, value_in;
   logic           final_ff, final_in;
   count_type      best_ff, best_in;
   count_type      count_ff, count_in;
   logic           dropped_ff, dropped_in;
   count_type      walk_ff, walk_in;
   count_type      need_ff, need_in;
   count_type      emit_ff, emit_in;

   search_req_type s_req;
   search_rsp_type s_rsp;

   logic           accept;
   logic           full;
   logic           store_wr;
   count_type      walk_m1;
   count_type      need_m1;
   logic           walk_rd_en;
   logic           seq_wr;
   logic           seq_rd_en;
   value_type      val_rd;
   count_type      rank_rd;
   value_type      seq_rd;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign full     = (count_ff == count_type'(MAX_ITEMS));
   assign store_wr = (state_ff == ST_SEARCH) && s_rsp.done;
   assign walk_m1  = walk_ff - 1'b1;
   assign need_m1  = need_ff - 1'b1;

   assign walk_rd_en = (state_ff == ST_WALK_RD) && (walk_ff != '0) && (need_ff != '0);
   assign seq_wr     = (state_ff == ST_WALK_CMP) && (rank_rd == need_ff);
   assign seq_rd_en  = (state_ff == ST_EMIT_RD) && (emit_ff != best_ff);

   assign s_req.start = accept && !full;
   assign s_req.value = req_value;
   assign s_req.limit = best_ff;

   lis_search u_search (
      .clock (clock),
      .reset (reset),
      .req   (s_req),
      .rsp   (s_rsp)
   );

   lis_ram #(
      .DATA_W (VALUE_WIDTH),
      .ADDR_W (IDX_W)
   ) u_values (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (value_ff),
      .rd_en   (walk_rd_en),
      .rd_addr (walk_m1[IDX_W-1:0]),
      .rd_data (val_rd)
   );

   lis_ram #(
      .DATA_W (CNT_W),
      .ADDR_W (IDX_W)
   ) u_ranks (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (s_rsp.pos + 1'b1),
      .rd_en   (walk_rd_en),
      .rd_addr (walk_m1[IDX_W-1:0]),
      .rd_data (rank_rd)
   );

   // The walk-back fills the subsequence from its end; the replay reads it
   // from the front.
   lis_ram #(
      .DATA_W (VALUE_WIDTH),
      .ADDR_W (IDX_W)
   ) u_seq (
      .clock   (clock),
      .wr_en   (seq_wr),
      .wr_addr (need_m1[IDX_W-1:0]),
      .wr_data (val_rd),
      .rd_en   (seq_rd_en),
      .rd_addr (emit_ff[IDX_W-1:0]),
      .rd_data (seq_rd)
   );

   always_comb begin
      state_in   = state_ff;
      value_in   = value_ff;
      final_in   = final_ff;
      best_in    = best_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      walk_in    = walk_ff;
      need_in    = need_ff;
      emit_in    = emit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in = req_value;
               final_in = req_final_req;
               if (full) begin
                  dropped_in = 1'b1;
                  if (req_final_req) begin
                     walk_in  = count_ff;
                     need_in  = best_ff;
                     state_in = ST_WALK_RD;
                  end
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (s_rsp.done) begin
               count_in = count_ff + 1'b1;
               if (s_rsp.pos == best_ff) begin
                  best_in = best_ff + 1'b1;
               end
               if (final_ff) begin
                  walk_in  = count_ff + 1'b1;
                  need_in  = best_in;
                  state_in = ST_WALK_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WALK_RD: begin
            if (walk_rd_en) begin
               state_in = ST_WALK_CMP;
            end else begin
               emit_in  = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_WALK_CMP: begin
            if (seq_wr) begin
               need_in = need_m1;
            end
            walk_in  = walk_m1;
            state_in = ST_WALK_RD;
         end
         ST_EMIT_RD: begin
            if (seq_rd_en) begin
               state_in = ST_EMIT_OUT;
            end else begin
               best_in    = '0;
               count_in   = '0;
               dropped_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         ST_EMIT_OUT: begin
            emit_in  = emit_ff + 1'b1;
            state_in = ST_EMIT_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         best_ff    <= '0;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         best_ff    <= best_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
      value_ff <= value_in;
      final_ff <= final_in;
      walk_ff  <= walk_in;
      need_ff  <= need_in;
      emit_ff  <= emit_in;
   end

   assign rsp_strobe   = (state_ff == ST_EMIT_OUT);
   assign rsp_element  = seq_rd;
   assign rsp_rank     = emit_ff + 1'b1;
   assign rsp_length   = best_ff;
   assign rsp_overflow = dropped_ff;
   assign rsp_tail     = rsp_strobe && ((emit_ff + 1'b1) == best_ff);

   `ASSERT_IMPLY(a_rank_range, clock, reset, rsp_strobe, (rsp_rank != '0) && (rsp_rank <= rsp_length))
   `ASSERT_NEXT(a_strobe_gap, clock, reset, rsp_strobe, !rsp_strobe && busy)
   `ASSERT_IMPLY(a_count_cap, clock, reset, 1'b1, (count_ff <= count_type'(MAX_ITEMS)) && (best_ff <= count_ff))
   `ASSERT_IMPLY(a_search_bound, clock, reset, s_rsp.done, s_rsp.pos <= best_ff)

endmodule

FILE: rtl/lis_ram.sv
// ----------------------------------------------------------------------------
// LIS RAM
// Simple dual-port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lis_ram #(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lis_search.sv
// ----------------------------------------------------------------------------
// LIS tail search
// Lower-bound binary search over the tails memory with one shared compare.
// ----------------------------------------------------------------------------
module lis_search (
   input  logic                    clock,
   input  logic                    reset,
   input  lis_pkg::search_req_type req,
   output lis_pkg::search_rsp_type rsp
);

   import lis_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_STEP = 2'd1;
   localparam logic [1:0] S_CMP  = 2'd2;

   logic [1:0] state_ff, state_in;
   count_type  lo_ff, lo_in;
   count_type  hi_ff, hi_in;
   value_type  val_ff, val_in;
   count_type  mid;
   logic       open;
   logic       finish;
   logic       rd_en;
   value_type  rd_data;

   // Midpoint of the open range; it stays put from the read to the compare.
   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign open   = lo_ff < hi_ff;
   assign finish = (state_ff == S_STEP) && !open;
   assign rd_en  = (state_ff == S_STEP) && open;

   lis_ram #(
      .DATA_W (VALUE_WIDTH),
      .ADDR_W (IDX_W)
   ) u_tails (
      .clock   (clock),
      .wr_en   (finish),
      .wr_addr (lo_ff[IDX_W-1:0]),
      .wr_data (val_ff),
      .rd_en   (rd_en),
      .rd_addr (mid[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      val_in   = val_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               lo_in    = '0;
               hi_in    = req.limit;
               val_in   = req.value;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (open) begin
               state_in = S_CMP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CMP: begin
            if (rd_data < val_ff) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
            state_in = S_STEP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      val_ff <= val_in;
   end

   assign rsp.done = finish;
   assign rsp.pos  = lo_ff;

endmodule
